>>> rtl/cpi_pkg.sv
`default_nettype none

package cpi_pkg;

  localparam int IDX_W = 8;
  localparam int CNT_W = 9;
  localparam int RGB_W = 24;

  localparam logic CMD_MERGE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_INSERTED  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic       command;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] palette_index;
    logic [1:0]       status;
    logic [CNT_W-1:0] colors_used;
  } result_t;

  // transaction as it travels from cell to cell
  typedef struct packed {
    logic             valid;
    logic             command;
    logic [RGB_W-1:0] rgb;
    logic             hit;
    logic             inserted;
    logic [IDX_W-1:0] index;
  } link_t;

endpackage

`default_nettype wire

>>> rtl/cpi_cell.sv
`default_nettype none

module cpi_cell #(
  parameter int POS = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [cpi_pkg::CNT_W-1:0] count,
  input  wire cpi_pkg::link_t        prev,
  output cpi_pkg::link_t             next
);

  logic [cpi_pkg::RGB_W-1:0] entry;
  cpi_pkg::link_t            link_next;
  logic                      write_en;

  localparam logic [cpi_pkg::CNT_W-1:0] MY_POS = cpi_pkg::CNT_W'(POS);

  always_comb begin
    link_next = prev;
    write_en  = 1'b0;
    if (prev.valid && !prev.hit) begin
      if ((MY_POS < count) && (entry == prev.rgb)) begin
        link_next.hit   = 1'b1;
        link_next.index = cpi_pkg::IDX_W'(POS);
      end else if ((MY_POS == count) && (prev.command == cpi_pkg::CMD_MERGE)) begin
        // first free slot: claim it
        write_en           = 1'b1;
        link_next.hit      = 1'b1;
        link_next.inserted = 1'b1;
        link_next.index    = cpi_pkg::IDX_W'(POS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next.valid <= 1'b0;
    end else begin
      next.valid <= link_next.valid;
    end
    next.command  <= link_next.command;
    next.rgb      <= link_next.rgb;
    next.hit      <= link_next.hit;
    next.inserted <= link_next.inserted;
    next.index    <= link_next.index;
    if (write_en) begin
      entry <= prev.rgb;
    end
  end

endmodule

`default_nettype wire

>>> rtl/color_palette_indexer.sv
`default_nettype none

// each transaction is registered in every palette cell in turn, then into done and result
// the search walks the row of palette cells one cell per cycle and the next transaction
// waits for the result
// reset clears the entry count, busy and done; palette cells keep their contents, no clearing pass
// results are shown for one cycle under done and the receiver cannot stall them

module color_palette_indexer #(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire cpi_pkg::item_t  item,
  output logic                 done,
  output cpi_pkg::result_t     result
);

  // entries in use
  logic [cpi_pkg::CNT_W-1:0] count;
  logic [cpi_pkg::CNT_W-1:0] count_next;

  // links[k] feeds cell k, links[PALETTE_DEPTH] leaves the last cell
  cpi_pkg::link_t links [PALETTE_DEPTH+1];
  cpi_pkg::link_t last;
  cpi_pkg::result_t result_next;

  logic accept;

  assign accept = start && !busy;

  // head of the chain, built straight from the accepted transaction
  always_comb begin
    links[0].valid    = accept;
    links[0].command  = item.command;
    links[0].rgb      = {item.red, item.green, item.blue};
    links[0].hit      = 1'b0;
    links[0].inserted = 1'b0;
    links[0].index    = '0;
  end

  // row of compare cells, each holds one palette entry
  for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
    cpi_cell #(
      .POS (k)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .count (count),
      .prev  (links[k]),
      .next  (links[k+1])
    );
  end

  assign last = links[PALETTE_DEPTH];

  // classify the transaction leaving the row
  always_comb begin
    count_next = count;
    result_next.palette_index = '0;
    if (last.hit && last.inserted) begin
      count_next                = count + cpi_pkg::CNT_W'(1);
      result_next.status        = cpi_pkg::ST_INSERTED;
      result_next.palette_index = last.index;
    end else if (last.hit) begin
      result_next.status        = cpi_pkg::ST_FOUND;
      result_next.palette_index = last.index;
    end else if (last.command == cpi_pkg::CMD_LOOKUP) begin
      // absent colour on a lookup
      result_next.status = cpi_pkg::ST_NOT_FOUND;
    end else begin
      // absent colour with no free cell left
      result_next.status = cpi_pkg::ST_OVERFLOW;
    end
    result_next.colors_used = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= last.valid;
      if (accept) begin
        busy <= 1'b1;
      end else if (last.valid) begin
        busy <= 1'b0;
      end
      if (last.valid) begin
        count <= count_next;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (last.valid) begin
      result <= result_next;
    end
  end

  a_done_frees: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("busy still set while result shown");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cpi_pkg::CNT_W'(PALETTE_DEPTH))
    else $error("entry count beyond palette depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == cpi_pkg::ST_INSERTED) |->
      (count == $past(count) + cpi_pkg::CNT_W'(1)))
    else $error("insert without count step");

  a_count_steady: assert property (@(posedge clk) disable iff (rst)
    !last.valid |=> $stable(count))
    else $error("count moved with no transaction finishing");

  a_error_index: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == cpi_pkg::ST_NOT_FOUND ||
              result.status == cpi_pkg::ST_OVERFLOW)) |-> (result.palette_index == '0))
    else $error("non-zero index on error status");

endmodule

`default_nettype wire

>>> dv/color_palette_indexer_tb.sv
`default_nettype none

module color_palette_indexer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 256;
  localparam int N_RANDOM   = 1930;
  // first part of the random stream leans on fresh merges so the palette fills up
  localparam int FILL_ITEMS = 500;
  localparam int MAX_SHOWN  = 10;

  logic             clk   = 1'b0;
  logic             rst   = 1'b1;
  logic             start = 1'b0;
  cpi_pkg::item_t   item  = '0;
  logic             busy;
  logic             done;
  cpi_pkg::result_t result;

  color_palette_indexer #(
    .PALETTE_DEPTH(DEPTH)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .item  (item),
    .done  (done),
    .result(result)
  );

  // transactions waiting to be offered, and results owed by the block
  cpi_pkg::item_t   pending_items[$];
  cpi_pkg::result_t owed_results[$];
  logic [23:0]      known_colours[$];

  // private copy of the palette, advanced once per accepted transaction
  logic [23:0] shadow_palette[DEPTH];
  int          shadow_count = 0;

  int n_total      = 0;
  int n_sent       = 0;
  int n_fail       = 0;
  int n_shown      = 0;
  int cycle_count  = 0;
  int idle_pct;
  int cycle_limit;

  initial begin
    forever #5 clk = ~clk;
  end

  // search the shadow palette, append on a merge miss, and give the result the block owes
  function automatic cpi_pkg::result_t palette_search(cpi_pkg::item_t it);
    cpi_pkg::result_t r;
    logic [23:0]      rgb;
    int               pos;
    rgb = {it.red, it.green, it.blue};
    pos = -1;
    // lowest matching entry wins
    for (int k = 0; k < shadow_count; k++) begin
      if (pos < 0 && shadow_palette[k] == rgb) pos = k;
    end
    r.palette_index = '0;
    if (pos >= 0) begin
      r.palette_index = 8'(pos);
      r.status = cpi_pkg::ST_FOUND;
    end else if (it.command == cpi_pkg::CMD_LOOKUP) begin
      r.status = cpi_pkg::ST_NOT_FOUND;
    end else if (shadow_count >= DEPTH) begin
      // absent colour, no room left: nothing changes
      r.status = cpi_pkg::ST_OVERFLOW;
    end else begin
      shadow_palette[shadow_count] = rgb;
      r.palette_index = 8'(shadow_count);
      shadow_count++;
      r.status = cpi_pkg::ST_INSERTED;
    end
    r.colors_used = 9'(shadow_count);
    return r;
  endfunction

  task automatic queue_colour(logic cmd, logic [23:0] rgb);
    cpi_pkg::item_t it;
    it.command = cmd;
    it.red     = rgb[23:16];
    it.green   = rgb[15:8];
    it.blue    = rgb[7:0];
    pending_items.push_back(it);
  endtask

  // channels biased towards their extremes
  function automatic logic [23:0] fresh_colour();
    logic [23:0] rgb;
    for (int c = 0; c < 3; c++) begin
      case ($urandom_range(0, 7))
        0: rgb[c*8 +: 8] = 8'h00;
        1: rgb[c*8 +: 8] = 8'hFF;
        default: rgb[c*8 +: 8] = 8'($urandom);
      endcase
    end
    return rgb;
  endfunction

  function automatic logic [23:0] old_colour();
    return known_colours[$urandom_range(0, known_colours.size() - 1)];
  endfunction

  // sender idling per phase: none, heavy, none (receiver cannot stall), light
  always_comb begin
    case ((n_total > 0) ? (n_sent * 4) / n_total : 0)
      1:       idle_pct = 86;
      3:       idle_pct = 19;
      default: idle_pct = 0;
    endcase
  end

  // driver: a transaction is taken at an edge with start high and busy low
  always @(posedge clk) begin : drive_p
    logic taken;
    if (rst) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        owed_results.push_back(palette_search(item));
        n_sent++;
      end
      if (start && !taken) begin
        // hold the offer until the block is free
      end else if (pending_items.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        start <= 1'b1;
        item  <= pending_items.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every done cycle carries exactly one result
  always @(posedge clk) begin : watch_p
    cpi_pkg::result_t want;
    if (!rst && done) begin
      if (owed_results.size() == 0) begin
        n_fail++;
        if (n_shown < MAX_SHOWN) begin
          $display("unexpected result: index %0d status %0d used %0d",
                   result.palette_index, result.status, result.colors_used);
          n_shown++;
        end
      end else begin
        want = owed_results.pop_front();
        if (result.palette_index !== want.palette_index || result.status !== want.status ||
            result.colors_used !== want.colors_used) begin
          n_fail++;
          if (n_shown < MAX_SHOWN) begin
            $display("mismatch: index %0d/%0d status %0d/%0d used %0d/%0d (expected/actual)",
                     want.palette_index, result.palette_index, want.status, result.status,
                     want.colors_used, result.colors_used);
            n_shown++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus_p
    int          pick;
    logic [23:0] rgb;
    cycle_limit = (N_RANDOM + 40) * (DEPTH + 10) * 4;

    // directed: empty palette, extremes, duplicates, lookup miss then merge
    queue_colour(cpi_pkg::CMD_LOOKUP, 24'h000000);
    queue_colour(cpi_pkg::CMD_LOOKUP, 24'hFFFFFF);
    queue_colour(cpi_pkg::CMD_MERGE,  24'h000000);
    queue_colour(cpi_pkg::CMD_MERGE,  24'h000000);
    queue_colour(cpi_pkg::CMD_LOOKUP, 24'h000000);
    queue_colour(cpi_pkg::CMD_MERGE,  24'hFFFFFF);
    queue_colour(cpi_pkg::CMD_MERGE,  24'hFF0000);
    queue_colour(cpi_pkg::CMD_MERGE,  24'h00FF00);
    queue_colour(cpi_pkg::CMD_MERGE,  24'h0000FF);
    queue_colour(cpi_pkg::CMD_LOOKUP, 24'hFF0000);
    queue_colour(cpi_pkg::CMD_LOOKUP, 24'h0000FF);
    queue_colour(cpi_pkg::CMD_LOOKUP, 24'h123456);
    queue_colour(cpi_pkg::CMD_LOOKUP, 24'h7F7F7F);
    queue_colour(cpi_pkg::CMD_MERGE,  24'h7F7F7F);
    queue_colour(cpi_pkg::CMD_LOOKUP, 24'h7F7F7F);
    queue_colour(cpi_pkg::CMD_MERGE,  24'h808080);
    queue_colour(cpi_pkg::CMD_MERGE,  24'h010101);
    queue_colour(cpi_pkg::CMD_MERGE,  24'hFFFFFF);
    queue_colour(cpi_pkg::CMD_LOOKUP, 24'hFFFFFE);
    queue_colour(cpi_pkg::CMD_MERGE,  24'hAA55AA);
    known_colours = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                      24'h7F7F7F, 24'h808080, 24'h010101, 24'hAA55AA};

    // random: fill the palette first, then mostly hits and overflows on a full palette
    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 99);
      if (i < FILL_ITEMS ? pick < 55 : pick < 25) begin
        rgb = fresh_colour();
        queue_colour(cpi_pkg::CMD_MERGE, rgb);
        if (known_colours.size() < DEPTH + 40) known_colours.push_back(rgb);
      end else if (i < FILL_ITEMS ? pick < 70 : pick < 50) begin
        queue_colour(cpi_pkg::CMD_MERGE, old_colour());
      end else if (i < FILL_ITEMS ? pick < 85 : pick < 85) begin
        queue_colour(cpi_pkg::CMD_LOOKUP, old_colour());
      end else begin
        queue_colour(cpi_pkg::CMD_LOOKUP, fresh_colour());
      end
    end
    n_total = pending_items.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // drain, then give the block a full search time to show anything stray
    while (pending_items.size() > 0 || start || owed_results.size() > 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (owed_results.size() != 0) n_fail++;

    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/cpi_pkg.sv
rtl/cpi_cell.sv
rtl/color_palette_indexer.sv
dv/color_palette_indexer_tb.sv
